// ===== sv/bfbp_pkg.sv =====
`timescale 1ns / 1ps

package bfbp_pkg;

  localparam int unsigned POOL_ENTRIES_DEF = 16;
  localparam int unsigned SIZE_W           = 32;
  localparam int unsigned HANDLE_W         = 4;
  localparam logic [SIZE_W-1:0] SIZE_ALL_ONES = '1;

  typedef enum logic [1:0] {
    FUNC_ACQUIRE = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_CLEAR   = 2'd2
  } bfbp_func_e;

  typedef enum logic [2:0] {
    ST_FIT   = 3'd0,
    ST_GROWN = 3'd1,
    ST_NEW   = 3'd2,
    ST_FULL  = 3'd3,
    ST_BADH  = 3'd4,
    ST_DONE  = 3'd5
  } bfbp_status_e;

  typedef struct packed {
    logic [1:0]          func;
    logic [SIZE_W-1:0]   request_size;
    logic [HANDLE_W-1:0] release_handle;
  } bfbp_req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] granted_handle;
    logic [SIZE_W-1:0]   granted_size;
    logic [2:0]          status;
  } bfbp_rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic scan_init;
    logic scan_step;
    logic finish;
    logic single;
  } bfbp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
  } bfbp_stat_t;

endpackage

// ===== sv/bfbp_ram.sv =====
`timescale 1ns / 1ps

module bfbp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bfbp_ctrl.sv =====
`timescale 1ns / 1ps

module bfbp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [1:0]           func_i,
  input  bfbp_pkg::bfbp_stat_t stat_i,
  output bfbp_pkg::bfbp_cmd_t  cmd_o,
  output logic                 busy_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (func_i == bfbp_pkg::FUNC_ACQUIRE) begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_SCAN;
          end else begin
            cmd_o.single = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== sv/bfbp_dp.sv =====
`timescale 1ns / 1ps

module bfbp_dp #(
  parameter int unsigned POOL_ENTRIES = bfbp_pkg::POOL_ENTRIES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bfbp_pkg::bfbp_cmd_t  cmd_i,
  input  bfbp_pkg::bfbp_req_t  req_i,
  output bfbp_pkg::bfbp_stat_t stat_o,
  output bfbp_pkg::bfbp_rsp_t  rsp_o,
  output logic                 done_o
);

  localparam int unsigned IW   = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int unsigned CW   = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned CMPW = (CW > bfbp_pkg::HANDLE_W) ? CW : bfbp_pkg::HANDLE_W;
  localparam int unsigned SW   = bfbp_pkg::SIZE_W;
  localparam int unsigned HW   = bfbp_pkg::HANDLE_W;

  logic [POOL_ENTRIES-1:0] busy_q, busy_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [CW-1:0]           idx_q, idx_d;
  logic                    rd_vld_q, rd_vld_d;
  logic [IW-1:0]           rd_idx_q, rd_idx_d;
  logic                    hit_q, hit_d;
  logic                    have_best_q, have_best_d;
  logic [IW-1:0]           best_q, best_d;
  logic [SW-1:0]           best_ex_q, best_ex_d;
  logic [SW-1:0]           best_size_q, best_size_d;
  logic                    have_free_q, have_free_d;
  logic [IW-1:0]           free_q, free_d;
  logic [SW-1:0]           req_q, req_d;
  bfbp_pkg::bfbp_rsp_t     rsp_q, rsp_d;
  logic                    done_q, done_d;

  logic          more;
  logic          rd_en;
  logic [SW-1:0] rd_data;
  logic [SW-1:0] excess;
  logic          we;
  logic [IW-1:0] waddr;
  logic [IW-1:0] res_idx;
  logic [IW+HW-1:0] res_wide;
  logic [CMPW-1:0] h_ext;
  logic [CMPW-1:0] cnt_ext;
  logic [IW-1:0]   h_idx;

  bfbp_ram #(
    .WIDTH (SW),
    .DEPTH (POOL_ENTRIES)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (req_q),
    .re_i    (rd_en),
    .raddr_i (idx_q[IW-1:0]),
    .rdata_o (rd_data)
  );

  assign more    = (idx_q < cnt_q);
  assign rd_en   = cmd_i.scan_step && !hit_q && more;
  assign excess  = rd_data - req_q;
  assign h_ext   = CMPW'(req_i.release_handle);
  assign cnt_ext = CMPW'(cnt_q);
  assign h_idx   = IW'(h_ext);
  assign res_wide = {{HW{1'b0}}, res_idx};

  assign stat_o.scan_done = hit_q || (!rd_vld_q && !more);

  always_comb begin
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    rd_vld_d    = rd_en;
    rd_idx_d    = idx_q[IW-1:0];
    hit_d       = hit_q;
    have_best_d = have_best_q;
    best_d      = best_q;
    best_ex_d   = best_ex_q;
    best_size_d = best_size_q;
    have_free_d = have_free_q;
    free_d      = free_q;
    req_d       = req_q;
    rsp_d       = rsp_q;
    done_d      = 1'b0;
    we          = 1'b0;
    waddr       = free_q;
    res_idx     = '0;

    if (cmd_i.scan_init) begin
      idx_d       = '0;
      rd_vld_d    = 1'b0;
      hit_d       = 1'b0;
      have_best_d = 1'b0;
      have_free_d = 1'b0;
      best_ex_d   = bfbp_pkg::SIZE_ALL_ONES;
      req_d       = req_i.request_size;
    end

    if (cmd_i.scan_step) begin
      if (rd_en) begin
        idx_d = idx_q + 1'b1;
      end
      // compare stage: word read in the previous cycle
      if (rd_vld_q && !hit_q && !busy_q[rd_idx_q]) begin
        if (!have_free_q) begin
          have_free_d = 1'b1;
          free_d      = rd_idx_q;
        end
        if (rd_data == req_q) begin
          hit_d       = 1'b1;
          have_best_d = 1'b1;
          best_d      = rd_idx_q;
          best_size_d = rd_data;
        end else if (rd_data > req_q) begin
          if (!have_best_q || excess < best_ex_q) begin
            have_best_d = 1'b1;
            best_d      = rd_idx_q;
            best_ex_d   = excess;
            best_size_d = rd_data;
          end
        end
      end
    end

    if (cmd_i.finish) begin
      done_d = 1'b1;
      if (have_best_q) begin
        res_idx              = best_q;
        busy_d[best_q]       = 1'b1;
        rsp_d.granted_handle = res_wide[HW-1:0];
        rsp_d.granted_size   = best_size_q;
        rsp_d.status         = bfbp_pkg::ST_FIT;
      end else if (have_free_q) begin
        res_idx              = free_q;
        busy_d[free_q]       = 1'b1;
        we                   = 1'b1;
        waddr                = free_q;
        rsp_d.granted_handle = res_wide[HW-1:0];
        rsp_d.granted_size   = req_q;
        rsp_d.status         = bfbp_pkg::ST_GROWN;
      end else if (cnt_q < CW'(POOL_ENTRIES)) begin
        res_idx              = cnt_q[IW-1:0];
        busy_d[cnt_q[IW-1:0]] = 1'b1;
        we                   = 1'b1;
        waddr                = cnt_q[IW-1:0];
        cnt_d                = cnt_q + 1'b1;
        rsp_d.granted_handle = res_wide[HW-1:0];
        rsp_d.granted_size   = req_q;
        rsp_d.status         = bfbp_pkg::ST_NEW;
      end else begin
        rsp_d.granted_handle = '0;
        rsp_d.granted_size   = '0;
        rsp_d.status         = bfbp_pkg::ST_FULL;
      end
    end

    if (cmd_i.single) begin
      done_d               = 1'b1;
      rsp_d.granted_handle = '0;
      rsp_d.granted_size   = '0;
      rsp_d.status         = bfbp_pkg::ST_DONE;
      case (req_i.func)
        bfbp_pkg::FUNC_RELEASE: begin
          if (h_ext < cnt_ext) begin
            busy_d[h_idx] = 1'b0;
          end else begin
            rsp_d.status = bfbp_pkg::ST_BADH;
          end
        end
        bfbp_pkg::FUNC_CLEAR: begin
          busy_d = '0;
          cnt_d  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      have_best_q <= 1'b0;
      have_free_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      rd_vld_q    <= rd_vld_d;
      hit_q       <= hit_d;
      have_best_q <= have_best_d;
      have_free_q <= have_free_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    best_q      <= best_d;
    best_ex_q   <= best_ex_d;
    best_size_q <= best_size_d;
    free_q      <= free_d;
    req_q       <= req_d;
    rsp_q       <= rsp_d;
  end

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

endmodule

// ===== sv/best_fit_buffer_pool_unit.sv =====
`timescale 1ns / 1ps

// Best-fit buffer pool. Raise start with a word on req_i while busy is low;
// the result word appears on rsp_o with done_o high for exactly one cycle and
// must be captured then, as the block cannot be stalled. Release, clear and
// unused codes answer in the next cycle and keep busy low. An acquire scans
// the entry table through the size RAM at one read a cycle (registered read
// port) and stops early on an exact free match; busy stays high until its
// result is out.
module best_fit_buffer_pool_unit #(
  parameter int unsigned POOL_ENTRIES = bfbp_pkg::POOL_ENTRIES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  bfbp_pkg::bfbp_req_t req_i,
  output bfbp_pkg::bfbp_rsp_t rsp_o,
  output logic                done_o
);

  bfbp_pkg::bfbp_cmd_t  cmd;
  bfbp_pkg::bfbp_stat_t stat;

  bfbp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .func_i (req_i.func),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  bfbp_dp #(
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .stat_o (stat),
    .rsp_o  (rsp_o),
    .done_o (done_o)
  );

endmodule
